FILE: rtl/pphpc_pkg.sv
// pphpc_pkg: shared types and codes of the planar pixel to ARGB converter
// used by every module under planar_pixel_ham_palette_convert; no dependencies
package pphpc_pkg;

  localparam int PLANE_W = 32;
  localparam int COMP_W  = 8;
  localparam int RGB_W   = 3 * COMP_W;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 3;

  // command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_COUNT       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_MODE         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HAM_ENABLE        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HALFBRIGHT_ENABLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSPARENT_INDEX = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_COUNT     = 3'd5;

  // mask modes
  localparam logic [1:0] MASK_NONE   = 2'd0;
  localparam logic [1:0] MASK_PLANE  = 2'd1;
  localparam logic [1:0] MASK_TRANSP = 2'd2;
  localparam logic [1:0] MASK_OTHER  = 2'd3;

  // hold-and-modify control codes
  localparam logic [1:0] HAM_RELOAD = 2'd0;
  localparam logic [1:0] HAM_BLUE   = 2'd1;
  localparam logic [1:0] HAM_RED    = 2'd2;
  localparam logic [1:0] HAM_GREEN  = 2'd3;

  localparam logic [COMP_W-1:0] ALPHA_OPAQUE = 8'hff;
  localparam logic [COMP_W-1:0] ALPHA_CLEAR  = 8'h00;

  localparam logic [5:0] PLANES_RESET = 6'd8;

  typedef enum logic [2:0] {
    MODE_DIRECT32,
    MODE_DIRECT24,
    MODE_HAM,
    MODE_EHB,
    MODE_PLAIN
  } pphpc_mode_t;

  typedef struct packed {
    logic              command;
    logic [31:0]       plane_bits;
    logic              mask_bit;
    logic              first_in_row;
    logic [7:0]        palette_index;
    logic [7:0]        palette_red;
    logic [7:0]        palette_green;
    logic [7:0]        palette_blue;
  } pphpc_in_t;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pphpc_out_t;

  typedef struct packed {
    logic [5:0]  plane_count;
    logic [1:0]  mask_mode;
    logic        ham_enable;
    logic        halfbright_enable;
    logic [15:0] transparent_index;
    logic [8:0]  palette_count;
  } pphpc_cfg_t;

  // decoded pixel held between the input and result registers
  typedef struct packed {
    pphpc_mode_t      mode;
    logic [7:0]       alpha;
    logic [23:0]      direct;
    logic [1:0]       ham_code;
    logic [7:0]       ham_value;
    logic             reload;
    logic             half;
    logic             pal_black;
  } pphpc_stage_t;

endpackage

FILE: rtl/pphpc_pal_mem.sv
// pphpc_pal_mem: palette store, one write port and one registered read port
// depends on pphpc_pkg for the entry width
module pphpc_pal_mem
  import pphpc_pkg::*;
#(
  parameter int ENTRIES = 256,
  parameter int AW      = 8
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [RGB_W-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [RGB_W-1:0] rd_data
);

  logic [RGB_W-1:0] mem [ENTRIES];
  logic [RGB_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/pphpc_decode.sv
// pphpc_decode: plane masking, mode selection, palette index and alpha of a pixel
// depends on pphpc_pkg for payload, configuration and stage types
module pphpc_decode
  import pphpc_pkg::*;
(
  input  pphpc_in_t    in_item,
  input  pphpc_cfg_t   cfg,
  output logic [7:0]   rd_index,
  output pphpc_stage_t stage
);

  logic [31:0] bits_m;
  logic [7:0]  low8;
  logic [5:0]  depth;
  logic        ham_ok;
  logic        ehb_ok;
  logic [7:0]  ham_v;
  logic [1:0]  ham_h;
  logic [7:0]  ham_m;
  logic [2:0]  dm1;
  logic [7:0]  ehb_v;
  logic        ehb_h;
  logic        transp;
  logic        in_range;
  logic [7:0]  alpha_base;

  assign depth = cfg.plane_count;

  always_comb begin
    for (int i = 0; i < PLANE_W; i++) begin
      bits_m[i] = in_item.plane_bits[i] & (6'(i) < depth);
    end
  end

  assign low8 = bits_m[7:0];

  assign ham_ok = cfg.ham_enable && (depth >= 6'd6) && (depth <= 6'd8);
  assign ehb_ok = cfg.halfbright_enable && (depth >= 6'd1) && (depth <= 6'd8);

  always_comb begin
    unique case (depth)
      6'd6: begin
        ham_v = {4'd0, low8[3:0]};
        ham_h = low8[5:4];
        ham_m = {low8[3:0], 4'd0};
      end
      6'd7: begin
        ham_v = {3'd0, low8[4:0]};
        ham_h = low8[6:5];
        ham_m = {low8[4:0], 3'd0};
      end
      default: begin
        ham_v = {2'd0, low8[5:0]};
        ham_h = low8[7:6];
        ham_m = {low8[5:0], 2'd0};
      end
    endcase
  end

  assign dm1   = depth[2:0] - 3'd1;
  assign ehb_h = low8[dm1];
  assign ehb_v = low8 & ~(8'd1 << dm1);

  assign alpha_base = ((cfg.mask_mode == MASK_NONE) ||
                       ((cfg.mask_mode == MASK_PLANE) && in_item.mask_bit) ||
                       (cfg.mask_mode == MASK_TRANSP)) ? ALPHA_OPAQUE : ALPHA_CLEAR;

  assign in_range = {1'b0, low8} < cfg.palette_count;

  always_comb begin
    stage           = '0;
    stage.direct    = bits_m[23:0];
    stage.ham_code  = ham_h;
    stage.ham_value = ham_m;
    stage.reload    = in_item.first_in_row || (ham_h == HAM_RELOAD);
    stage.half      = ehb_h;
    stage.alpha     = alpha_base;
    rd_index        = low8;
    transp          = 1'b0;
    priority if (depth == 6'd32) begin
      stage.mode  = MODE_DIRECT32;
      stage.alpha = bits_m[31:24];
    end else if (depth == 6'd24) begin
      stage.mode = MODE_DIRECT24;
    end else if (ham_ok) begin
      stage.mode = MODE_HAM;
      rd_index   = ham_v;
    end else if (ehb_ok) begin
      stage.mode = MODE_EHB;
      rd_index   = ehb_v;
      transp     = (cfg.mask_mode == MASK_TRANSP) &&
                   ({8'd0, ehb_v} == cfg.transparent_index);
    end else begin
      stage.mode      = MODE_PLAIN;
      stage.pal_black = !in_range;
      transp          = (cfg.mask_mode == MASK_TRANSP) &&
                        ({8'd0, low8} == cfg.transparent_index);
    end
    if (transp) begin
      stage.alpha = ALPHA_CLEAR;
    end
  end

endmodule

FILE: rtl/pphpc_color.sv
// pphpc_color: builds the result colour from the decoded pixel, palette data
// and the held colour; depends on pphpc_pkg
module pphpc_color
  import pphpc_pkg::*;
(
  input  pphpc_stage_t     stage,
  input  logic [RGB_W-1:0] pal_data,
  input  logic [7:0]       held_red,
  input  logic [7:0]       held_green,
  input  logic [7:0]       held_blue,
  output pphpc_out_t       result
);

  logic [RGB_W-1:0] pc;
  logic [7:0]       pr;
  logic [7:0]       pg;
  logic [7:0]       pb;

  assign pc = stage.pal_black ? '0 : pal_data;
  assign pr = pc[23:16];
  assign pg = pc[15:8];
  assign pb = pc[7:0];

  always_comb begin
    result.alpha = stage.alpha;
    result.red   = held_red;
    result.green = held_green;
    result.blue  = held_blue;
    unique case (stage.mode)
      MODE_DIRECT32, MODE_DIRECT24: begin
        result.red   = stage.direct[7:0];
        result.green = stage.direct[15:8];
        result.blue  = stage.direct[23:16];
      end
      MODE_HAM: begin
        if (stage.reload) begin
          result.red   = pr;
          result.green = pg;
          result.blue  = pb;
        end else begin
          unique case (stage.ham_code)
            HAM_BLUE:  result.blue  = stage.ham_value;
            HAM_RED:   result.red   = stage.ham_value;
            HAM_GREEN: result.green = stage.ham_value;
            default:   result.blue  = held_blue;
          endcase
        end
      end
      MODE_EHB: begin
        result.red   = stage.half ? {1'b0, pr[7:1]} : pr;
        result.green = stage.half ? {1'b0, pg[7:1]} : pg;
        result.blue  = stage.half ? {1'b0, pb[7:1]} : pb;
      end
      MODE_PLAIN: begin
        result.red   = pr;
        result.green = pg;
        result.blue  = pb;
      end
      default: begin
        result.red   = held_red;
      end
    endcase
  end

endmodule

FILE: rtl/planar_pixel_ham_palette_convert.sv
// planar_pixel_ham_palette_convert: top level, planar pixel to 8-bit ARGB
// depends on pphpc_pkg, pphpc_pal_mem, pphpc_decode and pphpc_color
// path: a pixel beat is registered in the input stage, then in the result stage
// throughput: one beat per cycle unless out_stall holds a full result stage; the palette
//   read port and the held-colour loop through the result stage each serve one pixel a cycle
// reset: synchronous rst_n empties both stages, clears the held colour and resets the
//   configuration registers; palette contents are not cleared
module planar_pixel_ham_palette_convert
  import pphpc_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pphpc_in_t            in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pphpc_out_t           out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int AW = $clog2(PALETTE_ENTRIES);

  pphpc_cfg_t       cfg_r;
  pphpc_stage_t     dec_stage;
  pphpc_stage_t     s1_r;
  pphpc_stage_t     s1_nxt;
  logic             s1_valid_r;
  logic             s1_valid_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  pphpc_out_t       out_r;
  pphpc_out_t       result;
  logic [7:0]       held_red_r;
  logic [7:0]       held_green_r;
  logic [7:0]       held_blue_r;
  logic [7:0]       rd_index;
  logic [RGB_W-1:0] pal_data;
  logic             in_accept;
  logic             pix_acc;
  logic             wr_en;
  logic             wr_oor;
  logic             rd_oor;
  logic             out_ready;
  logic             s1_adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.plane_count       <= PLANES_RESET;
      cfg_r.mask_mode         <= MASK_NONE;
      cfg_r.ham_enable        <= 1'b0;
      cfg_r.halfbright_enable <= 1'b0;
      cfg_r.transparent_index <= '0;
      cfg_r.palette_count     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PLANE_COUNT:       cfg_r.plane_count       <= cfg_wdata[5:0];
        CFG_MASK_MODE:         cfg_r.mask_mode         <= cfg_wdata[1:0];
        CFG_HAM_ENABLE:        cfg_r.ham_enable        <= cfg_wdata[0];
        CFG_HALFBRIGHT_ENABLE: cfg_r.halfbright_enable <= cfg_wdata[0];
        CFG_TRANSPARENT_INDEX: cfg_r.transparent_index <= cfg_wdata;
        CFG_PALETTE_COUNT:     cfg_r.palette_count     <= cfg_wdata[8:0];
        default:               cfg_r                   <= cfg_r;
      endcase
    end
  end

  // handshake
  assign out_ready = !out_valid_r || !out_stall;
  assign s1_adv    = s1_valid_r && out_ready;
  assign in_stall  = s1_valid_r && !out_ready;
  assign in_accept = in_valid && !in_stall;
  assign pix_acc   = in_accept && (in_data.command == CMD_PIXEL);

  assign wr_oor = {1'b0, in_data.palette_index} >= 9'(PALETTE_ENTRIES);
  assign wr_en  = in_accept && (in_data.command == CMD_WRITE) && !wr_oor;
  assign rd_oor = {1'b0, rd_index} >= 9'(PALETTE_ENTRIES);

  pphpc_decode u_decode (
    .in_item  (in_data),
    .cfg      (cfg_r),
    .rd_index (rd_index),
    .stage    (dec_stage)
  );

  pphpc_pal_mem #(
    .ENTRIES (PALETTE_ENTRIES),
    .AW      (AW)
  ) u_pal_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (in_data.palette_index[AW-1:0]),
    .wr_data ({in_data.palette_red, in_data.palette_green, in_data.palette_blue}),
    .rd_en   (pix_acc),
    .rd_addr (rd_index[AW-1:0]),
    .rd_data (pal_data)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (pix_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // input stage payload
  always_comb begin
    s1_nxt           = dec_stage;
    s1_nxt.pal_black = dec_stage.pal_black || rd_oor;
  end

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      s1_r <= s1_nxt;
    end
  end

  pphpc_color u_color (
    .stage      (s1_r),
    .pal_data   (pal_data),
    .held_red   (held_red_r),
    .held_green (held_green_r),
    .held_blue  (held_blue_r),
    .result     (result)
  );

  // held colour follows every pixel put out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_red_r   <= '0;
      held_green_r <= '0;
      held_blue_r  <= '0;
    end else if (s1_adv) begin
      held_red_r   <= result.red;
      held_green_r <= result.green;
      held_blue_r  <= result.blue;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: rtl/pphpc_checker.sv
// pphpc_checker: port-level checks of planar_pixel_ham_palette_convert
// depends on pphpc_pkg; bound to the top level at the end of this file
module pphpc_checker
  import pphpc_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input pphpc_in_t  in_data,
  input logic       out_valid,
  input logic       out_stall,
  input pphpc_out_t out_data
);

  // reset empties the result stage
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // input side backs up only behind a stalled full result stage
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("in_stall without a stalled result");

  // a fresh result beat comes from a pixel beat taken through the input stage
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall && (in_data.command == CMD_PIXEL), 2))
    else $error("result beat without a pixel beat");

endmodule

bind planar_pixel_ham_palette_convert pphpc_checker u_pphpc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

FILE: sim/pphpc_pixel_checker.sv
// pphpc_pixel_checker: watches the pixel, result and register ports of the converter,
// predicts each ARGB beat from its own palette and held colour, and counts mismatches
// depends on pphpc_pkg only
module pphpc_pixel_checker
  import pphpc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  pphpc_in_t            in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  pphpc_out_t           out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   mismatches,
  output int                   outstanding,
  output int                   pixels_checked,
  output int                   palette_writes
);

  pphpc_cfg_t        regs;
  logic [RGB_W-1:0]  pal_copy [256];
  logic [COMP_W-1:0] held_r, held_g, held_b;
  pphpc_out_t        expected_argb [$];
  pphpc_out_t        want;

  function automatic pphpc_out_t convert_pixel(input pphpc_in_t b);
    pphpc_out_t  r;
    pphpc_mode_t mode;
    logic [31:0] px;
    int unsigned depth, n, v, code;
    depth = regs.plane_count;
    px = b.plane_bits;
    if (depth == 0) begin
      px = '0;
    end else if (depth < 32) begin
      px = px & ~(32'hffffffff << depth);
    end
    if (depth == 32) begin
      mode = MODE_DIRECT32;
    end else if (depth == 24) begin
      mode = MODE_DIRECT24;
    end else if (regs.ham_enable && depth >= 6 && depth <= 8) begin
      mode = MODE_HAM;
    end else if (regs.halfbright_enable && depth >= 1 && depth <= 8) begin
      mode = MODE_EHB;
    end else begin
      mode = MODE_PLAIN;
    end
    r.alpha = (regs.mask_mode == MASK_NONE || (regs.mask_mode == MASK_PLANE && b.mask_bit) ||
               regs.mask_mode == MASK_TRANSP) ? ALPHA_OPAQUE : ALPHA_CLEAR;
    r.red = held_r;
    r.green = held_g;
    r.blue = held_b;
    case (mode)
      MODE_DIRECT32: begin
        r.alpha = px[31:24];
        r.blue = px[23:16];
        r.green = px[15:8];
        r.red = px[7:0];
      end
      MODE_DIRECT24: begin
        r.blue = px[23:16];
        r.green = px[15:8];
        r.red = px[7:0];
      end
      MODE_HAM: begin
        n = depth - 2;
        v = px & ((1 << n) - 1);
        code = (px >> n) & 3;
        if (b.first_in_row || code == HAM_RELOAD) begin
          {r.red, r.green, r.blue} = pal_copy[v];
        end else if (code == HAM_BLUE) begin
          r.blue = 8'(v << (8 - n));
        end else if (code == HAM_RED) begin
          r.red = 8'(v << (8 - n));
        end else begin
          r.green = 8'(v << (8 - n));
        end
      end
      MODE_EHB: begin
        n = depth - 1;
        v = px & ((1 << n) - 1);
        {r.red, r.green, r.blue} = pal_copy[v];
        if (px[n]) begin
          r.red = r.red >> 1;
          r.green = r.green >> 1;
          r.blue = r.blue >> 1;
        end
        if (regs.mask_mode == MASK_TRANSP && v == regs.transparent_index) r.alpha = ALPHA_CLEAR;
      end
      default: begin
        v = px & 255;
        if (v < regs.palette_count) begin
          {r.red, r.green, r.blue} = pal_copy[v];
        end else begin
          {r.red, r.green, r.blue} = '0;
        end
        if (regs.mask_mode == MASK_TRANSP && v == regs.transparent_index) r.alpha = ALPHA_CLEAR;
      end
    endcase
    held_r = r.red;
    held_g = r.green;
    held_b = r.blue;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      regs = '0;
      regs.plane_count = PLANES_RESET;
      held_r = '0;
      held_g = '0;
      held_b = '0;
      expected_argb.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PLANE_COUNT:       regs.plane_count = cfg_wdata[5:0];
          CFG_MASK_MODE:         regs.mask_mode = cfg_wdata[1:0];
          CFG_HAM_ENABLE:        regs.ham_enable = cfg_wdata[0];
          CFG_HALFBRIGHT_ENABLE: regs.halfbright_enable = cfg_wdata[0];
          CFG_TRANSPARENT_INDEX: regs.transparent_index = cfg_wdata[15:0];
          CFG_PALETTE_COUNT:     regs.palette_count = cfg_wdata[8:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_argb.size() == 0) begin
          mismatches++;
          $display("%0t: result beat with nothing pending, expected none got argb %h",
                   $time, out_data);
        end else begin
          want = expected_argb.pop_front();
          pixels_checked++;
          if (out_data.alpha !== want.alpha || out_data.red !== want.red ||
              out_data.green !== want.green || out_data.blue !== want.blue) begin
            mismatches++;
            $display("%0t: argb mismatch, expected %h got %h", $time, want, out_data);
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_data.command == CMD_WRITE) begin
          pal_copy[in_data.palette_index] =
            {in_data.palette_red, in_data.palette_green, in_data.palette_blue};
          palette_writes++;
        end else begin
          expected_argb.push_back(convert_pixel(in_data));
        end
      end
    end
    outstanding = expected_argb.size();
  end

endmodule

FILE: sim/tb_planar_pixel_ham_palette_convert.sv
// tb_planar_pixel_ham_palette_convert: drives palette writes and pixels through the
// converter under many register settings with random gaps and backpressure
// depends on pphpc_pkg, the converter rtl and pphpc_pixel_checker
module tb_planar_pixel_ham_palette_convert;
  import pphpc_pkg::*;

  localparam int HOLD_CYCLES = 80;
  localparam int RUN_LIMIT   = 1000000;
  localparam int PHASES      = 16;
  localparam int PHASE_BEATS = 40;
  localparam int SETTLE      = 4;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  pphpc_in_t            in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  pphpc_out_t           out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  int         mismatches, outstanding, pixels_checked, palette_writes;
  int         settings_used;
  pphpc_cfg_t cur;
  bit         written [256];
  bit         tx_idle, rx_idle, hold_req;

  always #1 clk = ~clk;

  planar_pixel_ham_palette_convert dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  pphpc_pixel_checker u_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .mismatches(mismatches), .outstanding(outstanding),
    .pixels_checked(pixels_checked), .palette_writes(palette_writes)
  );

  function automatic pphpc_in_t mk_pixel(input logic [31:0] bits, input logic mbit,
                                         input logic first);
    pphpc_in_t b;
    b.command = CMD_PIXEL;
    b.plane_bits = bits;
    b.mask_bit = mbit;
    b.first_in_row = first;
    b.palette_index = 8'($urandom);
    b.palette_red = 8'($urandom);
    b.palette_green = 8'($urandom);
    b.palette_blue = 8'($urandom);
    return b;
  endfunction

  function automatic pphpc_in_t mk_write(input logic [7:0] idx, input logic [7:0] r,
                                         input logic [7:0] g, input logic [7:0] bl);
    pphpc_in_t b;
    b.command = CMD_WRITE;
    b.plane_bits = $urandom;
    b.mask_bit = 1'($urandom);
    b.first_in_row = 1'($urandom);
    b.palette_index = idx;
    b.palette_red = r;
    b.palette_green = g;
    b.palette_blue = bl;
    return b;
  endfunction

  function automatic pphpc_cfg_t mk_cfg(input int depth, input logic [1:0] mm, input logic ham,
                                       input logic ehb, input int ti, input int cnt);
    pphpc_cfg_t c;
    c.plane_count = 6'(depth);
    c.mask_mode = mm;
    c.ham_enable = ham;
    c.halfbright_enable = ehb;
    c.transparent_index = 16'(ti);
    c.palette_count = 9'(cnt);
    return c;
  endfunction

  function automatic pphpc_cfg_t random_cfg(input int k);
    pphpc_cfg_t c;
    case (k % 8)
      0: c.plane_count = 6'd6;
      1: c.plane_count = 6'd8;
      2: c.plane_count = 6'd7;
      3: c.plane_count = 6'd24;
      4: c.plane_count = 6'd32;
      5: c.plane_count = 6'd0;
      6: c.plane_count = 6'd63;
      default: c.plane_count = 6'($urandom_range(1, 8));
    endcase
    c.mask_mode = 2'($urandom);
    c.ham_enable = ($urandom_range(0, 2) != 0);
    c.halfbright_enable = 1'($urandom);
    case ($urandom_range(0, 3))
      0: c.transparent_index = '0;
      1: c.transparent_index = 16'hffff;
      2: c.transparent_index = 16'($urandom_range(0, 255));
      default: c.transparent_index = 16'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0: c.palette_count = '0;
      1: c.palette_count = 9'd256;
      2: c.palette_count = 9'h1ff;
      default: c.palette_count = 9'($urandom_range(1, 255));
    endcase
    return c;
  endfunction

  // palette entry a pixel would read under the current settings, or -1
  function automatic int lookup_slot(input pphpc_in_t b);
    int unsigned depth, n;
    logic [31:0] px;
    depth = cur.plane_count;
    px = b.plane_bits;
    if (depth == 0) px = '0;
    else if (depth < 32) px = px & ~(32'hffffffff << depth);
    if (b.command == CMD_WRITE || depth == 32 || depth == 24) return -1;
    if (cur.ham_enable && depth >= 6 && depth <= 8) begin
      n = depth - 2;
      if (b.first_in_row || ((px >> n) & 3) == HAM_RELOAD) return px & ((1 << n) - 1);
      return -1;
    end
    if (cur.halfbright_enable && depth >= 1 && depth <= 8) return px & ((1 << (depth - 1)) - 1);
    if ((px & 255) < cur.palette_count) return px & 255;
    return -1;
  endfunction

  function automatic int pick_gap();
    int roll;
    if (!tx_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 2);
    if (roll < 97) return $urandom_range(3, 6);
    return $urandom_range(10, 30);
  endfunction

  task automatic send_beat(input pphpc_in_t b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    if (b.command == CMD_WRITE) written[b.palette_index] = 1'b1;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
  endtask

  // never let a pixel read an entry that was not written yet
  task automatic issue(input pphpc_in_t b);
    int slot;
    slot = lookup_slot(b);
    if (slot >= 0 && !written[slot])
      send_beat(mk_write(8'(slot), 8'($urandom), 8'($urandom), 8'($urandom)));
    send_beat(b);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic set_cfg(input pphpc_cfg_t c);
    wait_idle();
    cur = c;
    write_reg(CFG_PLANE_COUNT, {10'($urandom), c.plane_count});
    write_reg(CFG_MASK_MODE, {14'($urandom), c.mask_mode});
    write_reg(CFG_HAM_ENABLE, {15'($urandom), c.ham_enable});
    write_reg(CFG_HALFBRIGHT_ENABLE, {15'($urandom), c.halfbright_enable});
    write_reg(CFG_TRANSPARENT_INDEX, c.transparent_index);
    write_reg(CFG_PALETTE_COUNT, {7'($urandom), c.palette_count});
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // result side: random stall segments (none while rx_idle is low), or one long hold-off on request
  initial begin
    logic stall_val;
    int   seg, roll;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall_val = 1'b1;
        seg = HOLD_CYCLES;
      end else if (!rx_idle) begin
        stall_val = 1'b0;
        seg = 1;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
          stall_val = 1'b0;
          seg = $urandom_range(1, 6);
        end else if (roll < 95) begin
          stall_val = 1'b1;
          seg = $urandom_range(1, 3);
        end else begin
          stall_val = 1'b1;
          seg = $urandom_range(10, 30);
        end
      end
      out_stall <= stall_val;
      repeat (seg) @(posedge clk);
    end
  end

  initial begin
    int        ph, i, row_left;
    logic      first;
    pphpc_in_t b;
    cur = '0;
    cur.plane_count = PLANES_RESET;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    hold_req = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: plain lookup with no valid entries gives black
    issue(mk_write(8'd0, 8'hff, 8'hff, 8'hff));
    issue(mk_pixel(32'hffffffff, 1'b0, 1'b1));
    // direct argb and rgb
    set_cfg(mk_cfg(32, MASK_NONE, 1'b0, 1'b0, 0, 0));
    issue(mk_pixel(32'hffffffff, 1'b0, 1'b0));
    issue(mk_pixel(32'h00000000, 1'b1, 1'b1));
    issue(mk_pixel(32'h80ff0001, 1'b0, 1'b0));
    set_cfg(mk_cfg(24, MASK_PLANE, 1'b1, 1'b1, 16'hffff, 256));
    issue(mk_pixel(32'h00abcdef, 1'b1, 1'b0));
    issue(mk_pixel(32'hffffffff, 1'b0, 1'b0));
    // hold-and-modify, six planes: row start reload, then every control code
    set_cfg(mk_cfg(6, MASK_OTHER, 1'b1, 1'b0, 0, 256));
    issue(mk_write(8'd5, 8'h12, 8'h34, 8'h56));
    issue(mk_pixel(32'hffffff35, 1'b1, 1'b1));
    issue(mk_pixel(32'h0000001f, 1'b0, 1'b0));
    issue(mk_pixel(32'h00000020, 1'b1, 1'b0));
    issue(mk_pixel(32'h0000003a, 1'b0, 1'b0));
    issue(mk_pixel(32'h00000000, 1'b0, 1'b0));
    // hold-and-modify, eight planes, wins over half-brite
    set_cfg(mk_cfg(8, MASK_PLANE, 1'b1, 1'b1, 0, 0));
    issue(mk_write(8'd63, 8'h80, 8'h81, 8'h01));
    issue(mk_pixel(32'h000000bf, 1'b1, 1'b0));
    issue(mk_pixel(32'h0000003f, 1'b0, 1'b0));
    // half-brite with a transparent index hit
    set_cfg(mk_cfg(6, MASK_TRANSP, 1'b0, 1'b1, 3, 0));
    issue(mk_write(8'd3, 8'hff, 8'h81, 8'h7f));
    issue(mk_pixel(32'h00000023, 1'b0, 1'b0));
    issue(mk_pixel(32'h00000003, 1'b1, 1'b1));
    // zero planes, oversized plane count, out of range index
    set_cfg(mk_cfg(0, MASK_TRANSP, 1'b0, 1'b0, 0, 256));
    issue(mk_pixel(32'hffffffff, 1'b1, 1'b0));
    set_cfg(mk_cfg(63, MASK_NONE, 1'b0, 1'b1, 16'hffff, 5));
    issue(mk_pixel(32'hffffff03, 1'b0, 1'b0));
    issue(mk_pixel(32'h00000105, 1'b0, 1'b0));
    // single plane half-brite: the only bit is the halve bit
    set_cfg(mk_cfg(1, MASK_OTHER, 1'b0, 1'b1, 0, 256));
    issue(mk_pixel(32'h00000001, 1'b1, 1'b0));
    set_cfg(mk_cfg(8, MASK_NONE, 1'b0, 1'b0, 255, 256));
    issue(mk_write(8'd255, 8'h00, 8'hff, 8'h00));
    issue(mk_pixel(32'h000000ff, 1'b0, 1'b1));

    for (ph = 0; ph < PHASES; ph++) begin
      set_cfg(random_cfg(ph));
      tx_idle = (ph % 4 != 1);
      rx_idle = (ph % 4 != 2);
      row_left = 0;
      for (i = 0; i < PHASE_BEATS; i++) begin
        if (ph == 5 && i == 8) hold_req = 1'b1;
        if (ph == 9 && i == 20) wait_idle();
        first = (row_left == 0);
        if ($urandom_range(0, 3) == 0) begin
          b = mk_write(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        end else begin
          b = mk_pixel($urandom, 1'($urandom), first);
          if ($urandom_range(0, 7) == 0) b.plane_bits[7:0] = cur.transparent_index[7:0];
          if (first) row_left = $urandom_range(4, 24);
          row_left--;
        end
        issue(b);
      end
    end

    wait_idle();
    $display("covered %0d pixel beats and %0d palette writes under %0d register settings,",
             pixels_checked, palette_writes, settings_used);
    $display("with random gaps, a long result hold-off and a mid-run drain");
    if (mismatches == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("timeout with %0d results pending", outstanding);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: planar_pixel_ham_palette_convert.f
rtl/pphpc_pkg.sv
rtl/pphpc_pal_mem.sv
rtl/pphpc_decode.sv
rtl/pphpc_color.sv
rtl/planar_pixel_ham_palette_convert.sv
rtl/pphpc_checker.sv
sim/pphpc_pixel_checker.sv
sim/tb_planar_pixel_ham_palette_convert.sv
